// ===== design/tpd_pkg.sv =====
// Shared types and constants for the tag presence debouncer.
`default_nettype none

package tpd_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned DEBOUNCE_W = 16;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_MARK_PROCESSED = 2'd1;
    localparam logic [1:0] OP_ACK_REMOVED = 2'd2;

    typedef enum logic [1:0] {
        ST_NO_TAG    = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_PROCESSED = 2'd2,
        ST_REMOVED   = 2'd3
    } tag_state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic              present;
        logic [TIME_W-1:0] now_ms;
    } event_t;

    typedef struct packed {
        logic       took_effect;
        tag_state_t presence_state;
        logic       stable_level;
    } result_t;

endpackage

`default_nettype wire

// ===== design/tag_presence_debouncer.sv =====
// Top level of the tag presence debouncer: input register, core and result register.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  s_      | s_valid s_ready s_operation s_present s_now_ms | in
//  m_      | m_valid m_ready m_took_effect m_presence_state m_stable_level | out
//  cfg_    | cfg_valid cfg_ready cfg_debounce_ms        | in
//
// One item per cycle is accepted while the result side is not stalled.
// The item register feeds the core; its state updates as each item advances.
// Synchronous active-low reset empties both registers and restores the debounce time.
// A stalled result holds the pipeline; the input side stays ready while a slot is free.
`default_nettype none

module tag_presence_debouncer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_operation,
    input  wire logic                            s_present,
    input  wire logic [tpd_pkg::TIME_W-1:0]      s_now_ms,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_took_effect,
    output logic [1:0]                           m_presence_state,
    output logic                                 m_stable_level,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tpd_pkg::DEBOUNCE_W-1:0]  cfg_debounce_ms
);

    logic [tpd_pkg::DEBOUNCE_W-1:0] debounce_reg;
    logic                           in_valid_reg;
    tpd_pkg::event_t                in_item_reg;
    logic                           out_valid_reg;
    tpd_pkg::result_t               out_result_reg;
    tpd_pkg::result_t               core_result;
    logic                           advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= tpd_pkg::DEBOUNCE_RESET;
        end else if (cfg_valid) begin
            debounce_reg <= cfg_debounce_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.operation <= s_operation;
            in_item_reg.present   <= s_present;
            in_item_reg.now_ms    <= s_now_ms;
        end
    end

    tpd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .debounce_ms (debounce_reg),
        .step        (advance),
        .item        (in_item_reg),
        .result      (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_took_effect    = out_result_reg.took_effect;
    assign m_presence_state = out_result_reg.presence_state;
    assign m_stable_level   = out_result_reg.stable_level;

endmodule

`default_nettype wire

// ===== design/tpd_core.sv =====
// Debounce state, presence state machine and per-item result logic.
`default_nettype none

module tpd_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [tpd_pkg::DEBOUNCE_W-1:0] debounce_ms,
    input  wire logic                          step,
    input  wire tpd_pkg::event_t               item,
    output tpd_pkg::result_t                   result
);

    logic                       cand_valid_reg;
    logic                       cand_valid_next;
    logic                       cand_level_reg;
    logic                       cand_level_next;
    logic [tpd_pkg::TIME_W-1:0] cand_start_reg;
    logic [tpd_pkg::TIME_W-1:0] cand_start_next;
    logic                       stable_reg;
    logic                       stable_next;
    tpd_pkg::tag_state_t        state_reg;
    tpd_pkg::tag_state_t        state_next;
    logic [tpd_pkg::TIME_W-1:0] held;
    logic                       effect;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_valid_reg <= 1'b0;
            cand_level_reg <= 1'b0;
            cand_start_reg <= '0;
            stable_reg     <= 1'b0;
            state_reg      <= tpd_pkg::ST_NO_TAG;
        end else if (step) begin
            cand_valid_reg <= cand_valid_next;
            cand_level_reg <= cand_level_next;
            cand_start_reg <= cand_start_next;
            stable_reg     <= stable_next;
            state_reg      <= state_next;
        end
    end

    assign held = item.now_ms - cand_start_reg;

    always_comb begin
        cand_valid_next = cand_valid_reg;
        cand_level_next = cand_level_reg;
        cand_start_next = cand_start_reg;
        stable_next     = stable_reg;
        state_next      = state_reg;
        effect          = 1'b0;
        case (item.operation)
            tpd_pkg::OP_OBSERVE: begin
                if (!cand_valid_reg || (item.present != cand_level_reg)) begin
                    cand_valid_next = 1'b1;
                    cand_level_next = item.present;
                    cand_start_next = item.now_ms;
                end else if ((stable_reg != cand_level_reg) &&
                             (held >= {{(tpd_pkg::TIME_W-tpd_pkg::DEBOUNCE_W){1'b0}},
                                       debounce_ms})) begin
                    stable_next = cand_level_reg;
                    if (cand_level_reg) begin
                        if ((state_reg == tpd_pkg::ST_NO_TAG) ||
                            (state_reg == tpd_pkg::ST_REMOVED)) begin
                            state_next = tpd_pkg::ST_PRESENT;
                            effect     = 1'b1;
                        end
                    end else begin
                        if ((state_reg == tpd_pkg::ST_PRESENT) ||
                            (state_reg == tpd_pkg::ST_PROCESSED)) begin
                            state_next = tpd_pkg::ST_REMOVED;
                            effect     = 1'b1;
                        end
                    end
                end
            end
            tpd_pkg::OP_MARK_PROCESSED: begin
                if (state_reg == tpd_pkg::ST_PRESENT) begin
                    state_next = tpd_pkg::ST_PROCESSED;
                    effect     = 1'b1;
                end
            end
            tpd_pkg::OP_ACK_REMOVED: begin
                if ((state_reg == tpd_pkg::ST_REMOVED) && !stable_reg) begin
                    state_next = tpd_pkg::ST_NO_TAG;
                    effect     = 1'b1;
                end
            end
            default: begin
                effect = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.took_effect    = effect;
        result.presence_state = state_next;
        result.stable_level   = stable_next;
    end

endmodule

`default_nettype wire

// ===== design/tpd_checker.sv =====
// Port-level checks for the tag presence debouncer and the bind that attaches them.
`default_nettype none

module tpd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_took_effect,
    input wire logic [1:0] m_presence_state,
    input wire logic       m_stable_level
);

    // A tag counts as present or processed exactly while the stable level is high.
    a_state_matches_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_stable_level ==
            ((m_presence_state == tpd_pkg::ST_PRESENT) ||
             (m_presence_state == tpd_pkg::ST_PROCESSED))))
        else $error("presence state disagrees with stable level");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_took_effect) &&
            $stable(m_presence_state) && $stable(m_stable_level)))
        else $error("stalled result item changed");

endmodule

bind tag_presence_debouncer tpd_checker u_tpd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_took_effect    (m_took_effect),
    .m_presence_state (m_presence_state),
    .m_stable_level   (m_stable_level)
);

`default_nettype wire
